// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/shra_pkg.sv =====
// ----------------------------------------------------------------------------
// shra_pkg
// Types, report codes and helpers of the sensor hub report averager.
// ----------------------------------------------------------------------------
package shra_pkg;

    localparam int EXTRA_FRACTION_DEF = 8;
    localparam int COUNT_BITS_DEF     = 16;

    localparam int VEC_W     = 24;
    localparam int TIME_W    = 32;
    localparam int CNT_OUT_W = 16;
    localparam int REQ_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W     = 34;

    localparam int HEADER_LEN = 4;
    localparam int REPORT_MAX = 14;
    localparam int Q14_SHIFT  = 14;
    localparam int DIV_STEPS  = 24;

    localparam logic [15:0] POS_MAX = 16'hFFFF;

    localparam logic [BYTE_W-1:0] ID_TIME_BASE   = 8'hFB;
    localparam logic [BYTE_W-1:0] ID_TIME_REBASE = 8'hFA;
    localparam logic [BYTE_W-1:0] ID_GRAVITY     = 8'h06;
    localparam logic [BYTE_W-1:0] ID_ROTATION    = 8'h05;
    localparam logic [BYTE_W-1:0] ID_LINEAR      = 8'h04;
    localparam logic [BYTE_W-1:0] ID_ACCEL       = 8'h01;

    localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GRAV  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ACCEL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ACCURACY  = 2'd1;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_TIME = 3'd1,
        KIND_GRAV = 3'd2,
        KIND_ROT  = 3'd3,
        KIND_ACC  = 3'd4
    } kind_t;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_START = 9'b000000010,
        S_P1    = 9'b000000100,
        S_P2    = 9'b000001000,
        S_SMP   = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_ABS   = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_WB    = 9'b100000000
    } state_t;

    function automatic logic [3:0] kind_len(input kind_t k);
        logic [3:0] len;
        case (k)
            KIND_TIME: len = 4'd5;
            KIND_ROT:  len = 4'd14;
            default:   len = 4'd10;
        endcase
        return len;
    endfunction

    function automatic kind_t kind_decode(input logic [BYTE_W-1:0] b);
        kind_t k;
        case (b)
            ID_TIME_BASE, ID_TIME_REBASE: k = KIND_TIME;
            ID_GRAVITY:                   k = KIND_GRAV;
            ID_ROTATION:                  k = KIND_ROT;
            ID_LINEAR, ID_ACCEL:          k = KIND_ACC;
            default:                      k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (VEC_W - 1)) - 64'sd1;
        lo = -(64'sd1 <<< (VEC_W - 1));
        if (v > hi)
            return hi[VEC_W-1:0];
        else if (v < lo)
            return lo[VEC_W-1:0];
        return v[VEC_W-1:0];
    endfunction

endpackage

// ===== src/shra_if.sv =====
// ----------------------------------------------------------------------------
// shra interfaces
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface shra_req_if import shra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    modport source(output valid, req_type, data_byte, last_byte, input ready);
    modport sink(input valid, req_type, data_byte, last_byte, output ready);
endinterface

interface shra_res_if import shra_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [VEC_W-1:0]     vec_x;
    logic signed [VEC_W-1:0]     vec_y;
    logic signed [VEC_W-1:0]     vec_z;
    logic signed [TIME_W-1:0]    elapsed_ticks;
    logic        [CNT_OUT_W-1:0] sample_count;
    modport source(output valid, vec_x, vec_y, vec_z, elapsed_ticks, sample_count,
                   input ready);
    modport sink(input valid, vec_x, vec_y, vec_z, elapsed_ticks, sample_count,
                 output ready);
endinterface

interface shra_cfg_if import shra_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== src/sensor_hub_report_averager.sv =====
// ----------------------------------------------------------------------------
// sensor_hub_report_averager
// Parses sensor hub packets and keeps running means of gravity and acceleration.
// ----------------------------------------------------------------------------
// A read result is registered. A timestamp report only visits S_START; a
// gravity or accel fold runs S_SMP, S_MUL, S_ABS, S_DIV, S_WB per component,
// a rotation fold S_P1, S_P2 first (3 components, 24-step shared divider).
// Throughput: one request per cycle except while a report is handled or a
// result waits. Reset: asynchronous, active low; means, counts, times clear.
`include "assert_macros.svh"

module sensor_hub_report_averager import shra_pkg::*; #(
    parameter int EXTRA_FRACTION = EXTRA_FRACTION_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    shra_req_if.sink   in,
    shra_res_if.source out,
    shra_cfg_if.sink   cfg
);

    localparam int MB   = (COUNT_BITS + 1 > 16) ? COUNT_BITS + 1 : 16;
    localparam int PW   = VEC_W + MB;
    localparam int DW   = PW + 1;
    localparam int RW   = COUNT_BITS + 2;
    localparam int DCW  = $clog2(DIV_STEPS);
    localparam logic [DCW-1:0] DCNT_LAST = DCW'(DIV_STEPS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic signed [63:0] ROUND_ADJ = (64'sd1 <<< Q14_SHIFT) - 64'sd1;

    logic [BYTE_W-1:0] in_chan_reg;
    logic [1:0]        min_acc_reg;

    logic [15:0]       pos_reg;
    logic [BYTE_W-1:0] pkt_chan_reg;
    logic              stopped_reg;
    kind_t             kind_reg;
    kind_t             fin_kind_reg;
    logic [3:0]        off_reg;
    logic [BYTE_W-1:0] rb_reg [REPORT_MAX];

    logic signed [VEC_W-1:0] gm_reg [3];
    logic signed [VEC_W-1:0] am_reg [3];
    logic [COUNT_BITS-1:0]   gcnt_reg;
    logic [COUNT_BITS-1:0]   acnt_reg;
    logic [TIME_W-1:0]       gtime_reg;
    logic [TIME_W-1:0]       atime_reg;

    state_t                  state_reg;
    logic [1:0]              comp_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [VEC_W-1:0] s_reg;
    logic signed [DW-1:0]    d_reg;
    logic                    neg_reg;
    logic [RW-1:0]           rem_reg;
    logic [DIV_STEPS-1:0]    dq_reg;
    logic [DCW-1:0]          dcnt_reg;

    logic                    out_valid_reg;
    logic signed [VEC_W-1:0] out_x_reg;
    logic signed [VEC_W-1:0] out_y_reg;
    logic signed [VEC_W-1:0] out_z_reg;
    logic [TIME_W-1:0]       out_t_reg;
    logic [CNT_OUT_W-1:0]    out_n_reg;

    // request side
    logic        in_fire;
    logic        byte_fire;
    logic        parse_en;
    kind_t       dec_kind;
    kind_t       cur_kind;
    logic        rep_start;
    logic        unknown_id;
    logic [3:0]  wr_off;
    logic [3:0]  off_inc;
    logic        rep_done;

    assign in.ready  = (state_reg == S_IDLE) && (!out_valid_reg || out.ready);
    assign in_fire   = in.valid && in.ready;
    assign byte_fire = in_fire && (in.req_type == REQ_BYTE);
    assign parse_en  = byte_fire && (pos_reg >= 16'(HEADER_LEN))
                       && (pkt_chan_reg == in_chan_reg) && !stopped_reg;

    assign dec_kind   = kind_decode(in.data_byte);
    assign rep_start  = (kind_reg == KIND_NONE);
    assign cur_kind   = rep_start ? dec_kind : kind_reg;
    assign unknown_id = rep_start && (dec_kind == KIND_NONE);
    assign wr_off     = rep_start ? 4'd0 : off_reg;
    assign off_inc    = wr_off + 4'd1;
    assign rep_done   = !unknown_id && (off_inc >= kind_len(cur_kind));

    assign cfg.ready = 1'b1;

    // report fields, little endian at fixed offsets
    logic signed [15:0] qi;
    logic signed [15:0] qj;
    logic signed [15:0] qk;
    logic signed [15:0] qr;
    logic [TIME_W-1:0]  delta;
    logic               acc_ok;
    logic               tgt_grav;

    assign qi       = {rb_reg[5], rb_reg[4]};
    assign qj       = {rb_reg[7], rb_reg[6]};
    assign qk       = {rb_reg[9], rb_reg[8]};
    assign qr       = {rb_reg[11], rb_reg[10]};
    assign delta    = {rb_reg[4], rb_reg[3], rb_reg[2], rb_reg[1]};
    assign acc_ok   = (rb_reg[2][1:0] >= min_acc_reg);
    assign tgt_grav = (fin_kind_reg != KIND_ACC);

    // shared multiplier
    logic signed [VEC_W-1:0] mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [PW-1:0]    prod;
    logic signed [VEC_W-1:0] mean_sel;
    logic [COUNT_BITS-1:0]   cnt_sel;

    assign mean_sel = tgt_grav ? gm_reg[comp_reg] : am_reg[comp_reg];
    assign cnt_sel  = tgt_grav ? gcnt_reg : acnt_reg;

    always_comb
    begin
        mul_a = VEC_W'(qi);
        mul_b = MB'(qk);
        case (state_reg)
            S_P1:
            begin
                case (comp_reg)
                    2'd0:    begin mul_a = VEC_W'(qi); mul_b = MB'(qk); end
                    2'd1:    begin mul_a = VEC_W'(qj); mul_b = MB'(qk); end
                    default: begin mul_a = VEC_W'(qi); mul_b = MB'(qi); end
                endcase
            end
            S_P2:
            begin
                case (comp_reg)
                    2'd0:    begin mul_a = VEC_W'(qr); mul_b = MB'(qj); end
                    2'd1:    begin mul_a = VEC_W'(qr); mul_b = MB'(qi); end
                    default: begin mul_a = VEC_W'(qj); mul_b = MB'(qj); end
                endcase
            end
            S_MUL:
            begin
                mul_a = mean_sel;
                mul_b = $signed(MB'(cnt_sel));
            end
            default:
            begin
                mul_a = VEC_W'(qi);
                mul_b = MB'(qk);
            end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    // sample scaling
    logic signed [63:0]      g64;
    logic signed [63:0]      t64;
    logic signed [63:0]      rot_q;
    logic signed [15:0]      raw16;
    logic signed [VEC_W-1:0] sample;

    always_comb
    begin
        g64 = 64'(acc_reg) <<< 1;
        if (comp_reg == 2'd2)
            g64 = (64'sd1 <<< (2 * Q14_SHIFT)) - g64;
        t64 = g64 <<< EXTRA_FRACTION;
        // truncate toward zero
        rot_q = ((t64 < 0) ? (t64 + ROUND_ADJ) : t64) >>> Q14_SHIFT;
        case (comp_reg)
            2'd0:    raw16 = qi;
            2'd1:    raw16 = qj;
            default: raw16 = qk;
        endcase
        if (fin_kind_reg == KIND_ROT)
            sample = sat_vec(rot_q);
        else
            sample = sat_vec(64'(raw16) <<< EXTRA_FRACTION);
    end

    // divider step
    logic [DW-1:0]           mag;
    logic [RW-1:0]           divisor;
    logic [RW-1:0]           trial;
    logic signed [VEC_W:0]   quot;
    logic signed [VEC_W-1:0] quot_sat;

    assign mag      = d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
    assign divisor  = RW'(cnt_sel) + RW'(1);
    assign trial    = {rem_reg[RW-2:0], dq_reg[DIV_STEPS-1]};
    assign quot     = neg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});
    assign quot_sat = sat_vec(64'(quot));

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_chan_reg <= 8'd255;
            min_acc_reg <= 2'd2;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_INPUT_CHANNEL: in_chan_reg <= cfg.data;
                CFG_MIN_ACCURACY:  min_acc_reg <= cfg.data[1:0];
                default:           ;
            endcase
        end
    end

    // report byte store
    always_ff @(posedge clk)
    begin
        if (parse_en && !unknown_id)
            rb_reg[wr_off] <= in.data_byte;
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_P1: acc_reg <= ACC_W'(prod);
            S_P2:
            begin
                if (comp_reg == 2'd0)
                    acc_reg <= acc_reg - ACC_W'(prod);
                else
                    acc_reg <= acc_reg + ACC_W'(prod);
            end
            S_SMP: s_reg <= sample;
            S_MUL: d_reg <= DW'(prod) + DW'(s_reg);
            S_ABS:
            begin
                neg_reg <= d_reg[DW-1];
                rem_reg <= RW'(mag >> DIV_STEPS);
                dq_reg  <= mag[DIV_STEPS-1:0];
            end
            S_DIV:
            begin
                if (trial >= divisor)
                begin
                    rem_reg <= trial - divisor;
                    dq_reg  <= {dq_reg[DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    dq_reg  <= {dq_reg[DIV_STEPS-2:0], 1'b0};
                end
            end
            default: ;
        endcase
        if (in_fire && (in.req_type == REQ_GRAV))
        begin
            out_x_reg <= gm_reg[0];
            out_y_reg <= gm_reg[1];
            out_z_reg <= gm_reg[2];
            out_t_reg <= gtime_reg;
            out_n_reg <= CNT_OUT_W'(gcnt_reg);
        end
        else if (in_fire && (in.req_type == REQ_ACCEL))
        begin
            out_x_reg <= am_reg[0];
            out_y_reg <= am_reg[1];
            out_z_reg <= am_reg[2];
            out_t_reg <= atime_reg;
            out_n_reg <= CNT_OUT_W'(acnt_reg);
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            pkt_chan_reg  <= '0;
            stopped_reg   <= 1'b0;
            kind_reg      <= KIND_NONE;
            fin_kind_reg  <= KIND_NONE;
            off_reg       <= '0;
            gm_reg        <= '{default: '0};
            am_reg        <= '{default: '0};
            gcnt_reg      <= '0;
            acnt_reg      <= '0;
            gtime_reg     <= '0;
            atime_reg     <= '0;
            state_reg     <= S_IDLE;
            comp_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out.valid && out.ready)
                out_valid_reg <= 1'b0;

            if (in_fire && (in.req_type == REQ_GRAV))
            begin
                out_valid_reg <= 1'b1;
                gcnt_reg      <= COUNT_BITS'(1);
                gtime_reg     <= '0;
            end
            if (in_fire && (in.req_type == REQ_ACCEL))
            begin
                out_valid_reg <= 1'b1;
                acnt_reg      <= COUNT_BITS'(1);
                atime_reg     <= '0;
            end

            if (parse_en)
            begin
                if (unknown_id)
                    stopped_reg <= 1'b1;
                else if (rep_done)
                begin
                    kind_reg     <= KIND_NONE;
                    off_reg      <= '0;
                    fin_kind_reg <= cur_kind;
                    state_reg    <= S_START;
                end
                else
                begin
                    kind_reg <= cur_kind;
                    off_reg  <= off_inc;
                end
            end

            if (byte_fire)
            begin
                if (pos_reg == 16'd2)
                    pkt_chan_reg <= in.data_byte;
                if (pos_reg != POS_MAX)
                    pos_reg <= pos_reg + 16'd1;
                if (in.last_byte)
                begin
                    pos_reg     <= '0;
                    stopped_reg <= 1'b0;
                    kind_reg    <= KIND_NONE;
                    off_reg     <= '0;
                end
            end

            case (state_reg)
                S_IDLE: ;
                S_START:
                begin
                    comp_reg <= '0;
                    if (fin_kind_reg == KIND_TIME)
                    begin
                        gtime_reg <= gtime_reg + delta;
                        atime_reg <= atime_reg + delta;
                        state_reg <= S_IDLE;
                    end
                    else if (!acc_ok)
                        state_reg <= S_IDLE;
                    else if (fin_kind_reg == KIND_ROT)
                        state_reg <= S_P1;
                    else
                        state_reg <= S_SMP;
                end
                S_P1:  state_reg <= S_P2;
                S_P2:  state_reg <= S_SMP;
                S_SMP: state_reg <= S_MUL;
                S_MUL: state_reg <= S_ABS;
                S_ABS:
                begin
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg + DCW'(1);
                    if (dcnt_reg == DCNT_LAST)
                        state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (tgt_grav)
                        gm_reg[comp_reg] <= quot_sat;
                    else
                        am_reg[comp_reg] <= quot_sat;
                    if (comp_reg == 2'd2)
                    begin
                        if (tgt_grav && (gcnt_reg != CNT_MAX))
                            gcnt_reg <= gcnt_reg + COUNT_BITS'(1);
                        if (!tgt_grav && (acnt_reg != CNT_MAX))
                            acnt_reg <= acnt_reg + COUNT_BITS'(1);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= (fin_kind_reg == KIND_ROT) ? S_P1 : S_SMP;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out.valid         = out_valid_reg;
    assign out.vec_x         = out_x_reg;
    assign out.vec_y         = out_y_reg;
    assign out.vec_z         = out_z_reg;
    assign out.elapsed_ticks = out_t_reg;
    assign out.sample_count  = out_n_reg;

    `ASSERT_IMPL(a_ready_only_idle, in.ready, state_reg == S_IDLE, "request taken while busy")
    `ASSERT_IMPL(a_busy_no_report, state_reg != S_IDLE, kind_reg == KIND_NONE, "open report while busy")
    `ASSERT_ALWAYS(a_offset_range, off_reg < 4'(REPORT_MAX), "report offset out of range")
    `ASSERT_NEXT(a_div_len, state_reg == S_DIV && dcnt_reg == DCNT_LAST, state_reg == S_WB, "divide overrun")
    `ASSERT_IMPL(a_comp_range, state_reg != S_IDLE, comp_reg != 2'd3, "component index out of range")

endmodule

// ===== tb/sv/sensor_hub_report_averager_test.sv =====
// ----------------------------------------------------------------------------
// sensor_hub_report_averager_test
// Drives byte and read requests with random gaps and result stalls, predicts
// the mean vectors, times and sample counts, and checks every read result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_hub_report_averager_test;
    import shra_pkg::*;

    typedef struct packed {
        logic signed [VEC_W-1:0]     x;
        logic signed [VEC_W-1:0]     y;
        logic signed [VEC_W-1:0]     z;
        logic signed [TIME_W-1:0]    ticks;
        logic        [CNT_OUT_W-1:0] count;
    } mean_rd_t;

    class mean_scoreboard;
        logic [7:0]  chan_sel;
        logic [1:0]  acc_min;
        int unsigned pos;
        logic [7:0]  pkt_chan;
        bit          stopped;
        kind_t       kind;
        int unsigned offs;
        logic [7:0]  rbytes [16];
        longint      grav [3];
        longint      accl [3];
        longint      grav_n;
        longint      accl_n;
        logic [31:0] grav_t;
        logic [31:0] accl_t;
        mean_rd_t    pending [$];
        int          errors;
        int          reads_seen;

        function new();
            chan_sel = 8'hFF;
            acc_min = 2'd2;
            pos = 0;
            pkt_chan = 0;
            stopped = 0;
            kind = KIND_NONE;
            offs = 0;
            foreach (grav[i]) grav[i] = 0;
            foreach (accl[i]) accl[i] = 0;
            grav_n = 0;
            accl_n = 0;
            grav_t = 0;
            accl_t = 0;
            errors = 0;
            reads_seen = 0;
        endfunction

        function longint clip24(longint v);
            if (v > 64'sd8388607)
                return 64'sd8388607;
            if (v < -64'sd8388608)
                return -64'sd8388608;
            return v;
        endfunction

        function longint s16(int unsigned at);
            logic [15:0] u;
            u = {rbytes[(at + 1) & 15], rbytes[at & 15]};
            return longint'($signed(u));
        endfunction

        // SV division of signed operands truncates toward zero
        function void fold_in(ref longint m [3], ref longint n, input longint s [3]);
            for (int i = 0; i < 3; i++)
                m[i] = clip24((m[i] * n + s[i]) / (n + 1));
            if (n < 65535)
                n++;
        endfunction

        function void report_done();
            longint s [3];
            longint qi, qj, qk, qr;
            longint g [3];
            logic [31:0] d;
            if (kind == KIND_TIME) begin
                d = {rbytes[4], rbytes[3], rbytes[2], rbytes[1]};
                grav_t += d;
                accl_t += d;
                return;
            end
            if ((rbytes[2] & 8'h03) < acc_min)
                return;
            if (kind == KIND_ROT) begin
                qi = s16(4);
                qj = s16(6);
                qk = s16(8);
                qr = s16(10);
                g[0] = 2 * (qi * qk - qr * qj);
                g[1] = 2 * (qj * qk + qr * qi);
                g[2] = 64'sd268435456 - 2 * (qi * qi + qj * qj);
                for (int i = 0; i < 3; i++)
                    s[i] = clip24((g[i] * 256) / 16384);
                fold_in(grav, grav_n, s);
                return;
            end
            for (int i = 0; i < 3; i++)
                s[i] = clip24(s16(4 + 2 * i) * 256);
            if (kind == KIND_GRAV)
                fold_in(grav, grav_n, s);
            else
                fold_in(accl, accl_n, s);
        endfunction

        function void parse_byte(logic [7:0] b);
            int unsigned len;
            if (stopped)
                return;
            if (kind == KIND_NONE) begin
                kind = kind_decode(b);
                if (kind == KIND_NONE) begin
                    stopped = 1;
                    return;
                end
                offs = 0;
            end
            rbytes[offs & 15] = b;
            offs++;
            len = (kind == KIND_TIME) ? 5 : (kind == KIND_ROT) ? 14 : 10;
            if (offs >= len) begin
                report_done();
                kind = KIND_NONE;
                offs = 0;
            end
        endfunction

        function void note_request(logic [1:0] rt, logic [7:0] b, logic lst);
            mean_rd_t r;
            if (rt == REQ_GRAV) begin
                r = '{grav[0][23:0], grav[1][23:0], grav[2][23:0], grav_t, grav_n[15:0]};
                pending.push_back(r);
                grav_n = 1;
                grav_t = 0;
            end else if (rt == REQ_ACCEL) begin
                r = '{accl[0][23:0], accl[1][23:0], accl[2][23:0], accl_t, accl_n[15:0]};
                pending.push_back(r);
                accl_n = 1;
                accl_t = 0;
            end else if (rt == REQ_BYTE) begin
                if (pos == 2)
                    pkt_chan = b;
                if (pos >= HEADER_LEN && pkt_chan == chan_sel)
                    parse_byte(b);
                if (pos < 65535)
                    pos++;
                if (lst) begin
                    pos = 0;
                    stopped = 0;
                    kind = KIND_NONE;
                    offs = 0;
                end
            end
        endfunction

        function void check_result(mean_rd_t got);
            mean_rd_t exp_r;
            reads_seen++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got.x !== exp_r.x || got.y !== exp_r.y || got.z !== exp_r.z ||
                got.ticks !== exp_r.ticks || got.count !== exp_r.count) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp x=%0d y=%0d z=%0d t=%0d n=%0d got x=%0d y=%0d z=%0d t=%0d n=%0d",
                        exp_r.x, exp_r.y, exp_r.z, exp_r.ticks, exp_r.count,
                        got.x, got.y, got.z, got.ticks, got.count);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    shra_req_if req_ch();
    shra_res_if res_ch();
    shra_cfg_if cfg_ch();
    mean_scoreboard sb;

    sensor_hub_report_averager u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in(req_ch.sink),
        .out(res_ch.source),
        .cfg(cfg_ch.sink)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_BYTE;
        req_ch.data_byte = 8'h00;
        req_ch.last_byte = 1'b0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_INPUT_CHANNEL;
        cfg_ch.data = 8'h00;
        sb = new();
    end

    initial
    begin
        #30ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random stalls, check on accept
    initial
    begin
        int gap;
        @(posedge clk);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
            sb.check_result('{res_ch.vec_x, res_ch.vec_y, res_ch.vec_z,
                              res_ch.elapsed_ticks, res_ch.sample_count});
        end
    end

    bit burst;

    task automatic send(logic [1:0] rt, logic [7:0] b, logic lst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.data_byte <= b;
        req_ch.last_byte <= lst;
        do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
        sb.note_request(rt, b, lst);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_INPUT_CHANNEL)
            sb.chan_sel = val;
        else
            sb.acc_min = val[1:0];
        @(posedge clk);
    endtask

    // wait for all reads and any fold in flight
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic send_packet(logic [7:0] chan, logic [7:0] body [$]);
        logic [7:0] hdr [4];
        hdr[0] = 8'($urandom);
        hdr[1] = 8'($urandom);
        hdr[2] = chan;
        hdr[3] = 8'($urandom);
        for (int i = 0; i < 4; i++)
            send(REQ_BYTE, hdr[i], body.size() == 0 && i == 3);
        foreach (body[i])
            send(REQ_BYTE, body[i], i == body.size() - 1);
    endtask

    function automatic void add_vec(ref logic [7:0] q [$], input logic [7:0] id,
                                    input logic [7:0] st, input int nwords, input bit wild);
        logic [15:0] w;
        q.push_back(id);
        q.push_back(8'($urandom));
        q.push_back(st);
        q.push_back(8'($urandom));
        for (int i = 0; i < nwords; i++)
        begin
            // near-unit quaternion/vector magnitudes unless wild, plus extremes and random words
            case ($urandom_range(0, 3))
                0: w = wild ? 16'($urandom) : 16'h4000;
                1: w = 16'h8000;
                2: w = 16'h7FFF;
                default: w = 16'($urandom);
            endcase
            if (!wild && $urandom_range(0, 1))
                w = 16'($urandom_range(0, 16'h7FFF) - 16'h3FFF);
            q.push_back(w[7:0]);
            q.push_back(w[15:8]);
        end
    endfunction

    function automatic void add_time(ref logic [7:0] q [$], input logic [31:0] d);
        q.push_back($urandom_range(0, 1) ? ID_TIME_BASE : ID_TIME_REBASE);
        for (int i = 0; i < 4; i++)
            q.push_back(d[8 * i +: 8]);
    endfunction

    function automatic void add_random_report(ref logic [7:0] q [$], input logic [7:0] st);
        case ($urandom_range(0, 5))
            0: add_time(q, $urandom);
            1: add_vec(q, ID_GRAVITY, st, 3, 1);
            2: add_vec(q, ID_ROTATION, st, 5, 1'($urandom_range(0, 1)));
            3: add_vec(q, ID_LINEAR, st, 3, 1);
            4: add_vec(q, ID_ACCEL, st, 3, 1);
            default: add_time(q, $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
        endcase
    endfunction

    initial
    begin
        logic [7:0] body [$];
        logic [7:0] chans [4];
        int items;
        int n;
        burst = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reads with nothing folded, reset channel
        send(REQ_GRAV, 8'hFF, 1'b1);
        send(REQ_ACCEL, 8'h00, 1'b0);
        send(2'd3, 8'hAA, 1'b1);
        drain();
        write_reg(CFG_INPUT_CHANNEL, 8'h00);
        write_reg(CFG_MIN_ACCURACY, 8'd0);

        // each report kind, an unknown id stop, a cut-off report, a short packet
        body.delete();
        add_time(body, 32'hFFFFFFFF);
        add_vec(body, ID_GRAVITY, 8'h00, 3, 1);
        add_vec(body, ID_ROTATION, 8'h03, 5, 0);
        add_vec(body, ID_LINEAR, 8'h01, 3, 1);
        add_vec(body, ID_ACCEL, 8'h02, 3, 1);
        body.push_back(8'h77);
        add_time(body, 32'h1);
        send_packet(8'h00, body);
        body.delete();
        add_vec(body, ID_GRAVITY, 8'h03, 3, 1);
        body = body[0:5];
        send_packet(8'h00, body);
        send(REQ_BYTE, 8'h00, 1'b0);
        send(REQ_BYTE, 8'h00, 1'b1);
        send(REQ_GRAV, 8'h00, 1'b0);
        send(REQ_ACCEL, 8'h00, 1'b0);
        drain();

        chans[0] = 8'h00;
        chans[1] = 8'hFF;
        chans[2] = 8'h03;
        chans[3] = 8'h5A;
        items = 0;
        while (items < 2000)
        begin
            write_reg(CFG_INPUT_CHANNEL, chans[2'($urandom_range(0, 3))]);
            write_reg(CFG_MIN_ACCURACY, 8'($urandom_range(0, 3)));
            repeat ($urandom_range(4, 10))
            begin
                burst = ($urandom_range(0, 4) == 0);
                body.delete();
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    add_random_report(body, 8'($urandom));
                if ($urandom_range(0, 5) == 0)
                    body.push_back(8'($urandom));
                if ($urandom_range(0, 5) == 0)
                    body = body[0:$urandom_range(0, body.size() - 1)];
                send_packet(($urandom_range(0, 4) == 0) ? 8'($urandom) : sb.chan_sel, body);
                items += body.size() + 4;
                repeat ($urandom_range(0, 2))
                begin
                    send(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
                    items++;
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sensor_hub_report_averager.f =====
+incdir+src
src/shra_pkg.sv
src/shra_if.sv
src/sensor_hub_report_averager.sv
tb/sv/sensor_hub_report_averager_test.sv
